// File: src/pus_pkg.sv
package pus_pkg;

   // Field and datapath widths fixed by the channel definitions
   localparam int COORD_W     = 12;
   localparam int SCALE_W     = 8;
   localparam int OFFSET_W    = 13;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 21;
   localparam int PROD_W      = COORD_W + RECIP_W;

   // Result queue
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = 4;
   localparam int FIFO_CW    = 5;

   // Request opcodes
   localparam logic [1:0] OP_WRITE_PALETTE = 2'd0;
   localparam logic [1:0] OP_WRITE_PIXEL   = 2'd1;
   localparam logic [1:0] OP_EMIT          = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd1920;
   localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd1080;

   localparam logic [31:0] BORDER_COLOR = 32'hFF00_0000;

   typedef enum logic [1:0] {
      GEO_IDLE,
      GEO_SCALE,
      GEO_RECIP
   } geo_state_type;

   // Frame geometry handed from the geometry unit to the pixel pipeline
   typedef struct packed {
      logic                       busy;
      logic [COORD_W-1:0]         width;
      logic [COORD_W-1:0]         height;
      logic [COORD_W-1:0]         img_w;
      logic [COORD_W-1:0]         img_h;
      logic signed [OFFSET_W-1:0] off_x;
      logic signed [OFFSET_W-1:0] off_y;
      logic [RECIP_W-1:0]         recip;
   } geo_type;

   typedef struct packed {
      logic [31:0]        color;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               frame_end;
   } rsp_type;

endpackage

// File: src/pus_if.sv
interface pus_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] write_index;
   logic [31:0] color_value;
   logic [7:0]  pixel_value;

   modport source (output valid, opcode, write_index, color_value, pixel_value, input ready);
   modport sink (input valid, opcode, write_index, color_value, pixel_value, output ready);
endinterface

interface pus_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_color;
   logic [11:0] out_x;
   logic [11:0] out_y;
   logic        frame_end;

   modport source (output valid, out_color, out_x, out_y, frame_end, input ready);
   modport sink (input valid, out_color, out_x, out_y, frame_end, output ready);
endinterface

interface pus_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [11:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/pus_geom.sv
module pus_geom #(
   parameter int SRC_WIDTH  = 320,
   parameter int SRC_HEIGHT = 200
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [pus_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pus_pkg::COORD_W-1:0]          csr_data,
   output pus_pkg::geo_type                     geo
);

   localparam int CW = pus_pkg::COORD_W;
   localparam int OW = pus_pkg::OFFSET_W;
   localparam int SW = pus_pkg::SCALE_W;
   localparam int RW = pus_pkg::RECIP_W;
   localparam logic [CW:0]   SRC_W_EXT = (CW+1)'(SRC_WIDTH);
   localparam logic [CW:0]   SRC_H_EXT = (CW+1)'(SRC_HEIGHT);
   localparam logic [RW-1:0] RECIP_ONE = RW'(2 ** pus_pkg::RECIP_SHIFT);

   pus_pkg::geo_state_type state_ff, state_in;

   logic [CW-1:0]        width_ff, width_in;
   logic [CW-1:0]        height_ff, height_in;
   logic [SW-1:0]        scale_ff, scale_in;
   logic [CW-1:0]        img_w_ff, img_w_in;
   logic [CW-1:0]        img_h_ff, img_h_in;
   logic signed [OW-1:0] off_x_ff, off_x_in;
   logic signed [OW-1:0] off_y_ff, off_y_in;
   logic [RW-1:0]        recip_ff, recip_in;
   logic [SW-1:0]        rem_ff, rem_in;
   logic [RW-1:0]        quo_ff, quo_in;
   logic [RW-1:0]        num_ff, num_in;
   logic [4:0]           step_ff, step_in;

   logic [CW-1:0]        width_eff;
   logic [CW-1:0]        height_eff;
   logic                 fits;
   logic signed [OW-1:0] diff_x, diff_y, diff_x_up, diff_y_up;
   logic signed [OW-1:0] centre_x, centre_y;
   logic [SW:0]          rem_try;
   logic                 rem_ge;
   logic [SW-1:0]        rem_next;

   // Treat a zero screen size as one pixel
   assign width_eff  = (width_ff == '0) ? CW'(1) : width_ff;
   assign height_eff = (height_ff == '0) ? CW'(1) : height_ff;

   // Next scale still fits both axes
   assign fits = (({1'b0, img_w_ff} + SRC_W_EXT) <= {1'b0, width_eff}) &&
                 (({1'b0, img_h_ff} + SRC_H_EXT) <= {1'b0, height_eff});

   // Centring offset, halved towards zero
   assign diff_x    = $signed({1'b0, width_eff}) - $signed({1'b0, img_w_ff});
   assign diff_y    = $signed({1'b0, height_eff}) - $signed({1'b0, img_h_ff});
   assign diff_x_up = diff_x + OW'(1);
   assign diff_y_up = diff_y + OW'(1);
   assign centre_x  = diff_x[OW-1] ? (diff_x_up >>> 1) : (diff_x >>> 1);
   assign centre_y  = diff_y[OW-1] ? (diff_y_up >>> 1) : (diff_y >>> 1);

   // One restoring division step of the reciprocal
   assign rem_try  = {rem_ff, num_ff[RW-1]};
   assign rem_ge   = rem_try >= {1'b0, scale_ff};
   assign rem_next = rem_ge ? SW'(rem_try - {1'b0, scale_ff}) : rem_try[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pus_pkg::GEO_SCALE;
         width_ff  <= pus_pkg::WIDTH_RESET;
         height_ff <= pus_pkg::HEIGHT_RESET;
         scale_ff  <= SW'(1);
         img_w_ff  <= CW'(SRC_WIDTH);
         img_h_ff  <= CW'(SRC_HEIGHT);
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         scale_ff  <= scale_in;
         img_w_ff  <= img_w_in;
         img_h_ff  <= img_h_in;
      end
   end

   always_ff @(posedge clock) begin
      off_x_ff <= off_x_in;
      off_y_ff <= off_y_in;
      recip_ff <= recip_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      num_ff   <= num_in;
      step_ff  <= step_in;
   end

   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      scale_in  = scale_ff;
      img_w_in  = img_w_ff;
      img_h_in  = img_h_ff;
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      recip_in  = recip_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      num_in    = num_ff;
      step_in   = step_ff;

      case (state_ff)
         pus_pkg::GEO_IDLE: begin
            state_in = pus_pkg::GEO_IDLE;
         end
         // Grow the scale one step a cycle while the image still fits
         pus_pkg::GEO_SCALE: begin
            if (fits) begin
               scale_in = scale_ff + SW'(1);
               img_w_in = img_w_ff + CW'(SRC_WIDTH);
               img_h_in = img_h_ff + CW'(SRC_HEIGHT);
            end else begin
               off_x_in = centre_x;
               off_y_in = centre_y;
               num_in   = RECIP_ONE + RW'(scale_ff) - RW'(1);
               rem_in   = '0;
               quo_in   = '0;
               step_in  = 5'(RW - 1);
               state_in = pus_pkg::GEO_RECIP;
            end
         end
         // Ceiling reciprocal of the scale, one quotient bit a cycle
         pus_pkg::GEO_RECIP: begin
            rem_in  = rem_next;
            quo_in  = {quo_ff[RW-2:0], rem_ge};
            num_in  = {num_ff[RW-2:0], 1'b0};
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               recip_in = {quo_ff[RW-2:0], rem_ge};
               state_in = pus_pkg::GEO_IDLE;
            end
         end
         default: begin
            state_in = pus_pkg::GEO_IDLE;
         end
      endcase

      // A register write restarts the geometry from scale one
      if (csr_valid) begin
         case (csr_index)
            pus_pkg::CSR_SCREEN_WIDTH:  width_in  = csr_data;
            pus_pkg::CSR_SCREEN_HEIGHT: height_in = csr_data;
            default: ;
         endcase
         scale_in = SW'(1);
         img_w_in = CW'(SRC_WIDTH);
         img_h_in = CW'(SRC_HEIGHT);
         state_in = pus_pkg::GEO_SCALE;
      end
   end

   assign geo.busy   = (state_ff != pus_pkg::GEO_IDLE);
   assign geo.width  = width_eff;
   assign geo.height = height_eff;
   assign geo.img_w  = img_w_ff;
   assign geo.img_h  = img_h_ff;
   assign geo.off_x  = off_x_ff;
   assign geo.off_y  = off_y_ff;
   assign geo.recip  = recip_ff;

endmodule

// File: src/pus_pipe.sv
module pus_pipe #(
   parameter int SRC_WIDTH     = 320,
   parameter int SRC_HEIGHT    = 200,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [1:0]                  opcode,
   input  logic [15:0]                 write_index,
   input  logic [31:0]                 color_value,
   input  logic [7:0]                  pixel_value,
   input  pus_pkg::geo_type            geo,
   output logic                        push,
   output pus_pkg::rsp_type            push_data
);

   localparam int CW        = pus_pkg::COORD_W;
   localparam int OW        = pus_pkg::OFFSET_W;
   localparam int PW        = pus_pkg::PROD_W;
   localparam int SRC_DEPTH = SRC_WIDTH * SRC_HEIGHT;
   localparam int SRC_AW    = $clog2(SRC_DEPTH);
   localparam int PAL_AW    = $clog2(PALETTE_DEPTH);
   localparam int XW        = $clog2(SRC_WIDTH);
   localparam int YW        = $clog2(SRC_HEIGHT);

   typedef struct packed {
      logic [1:0]    op;
      logic [15:0]   wi;
      logic [31:0]   color;
      logic [7:0]    pix;
      logic [CW-1:0] col;
      logic [CW-1:0] row;
      logic          fend;
      logic          in_image;
   } item_type;

   // Source frame and palette stores
   logic [7:0]  src_mem [SRC_DEPTH];
   logic [31:0] pal_mem [PALETTE_DEPTH];

   logic [CW-1:0] raster_col_ff, raster_col_in;
   logic [CW-1:0] raster_row_ff, raster_row_in;

   logic     s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   item_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff;
   item_type s1_in, s2_in;

   logic [CW-1:0]     dx_ff, dy_ff;
   logic [XW-1:0]     sx_ff;
   logic [YW-1:0]     sy_ff;
   logic [SRC_AW-1:0] src_addr_ff, src_addr_in;
   logic              src_we_ff, src_we_in;
   logic [7:0]        src_q_ff;
   logic [31:0]       pal_q_ff;
   logic              oob_ff;

   logic [CW-1:0]       col_now, row_now, row_step, col_inc, row_inc;
   logic                col_over;
   logic signed [OW:0]  dx_full, dy_full;
   logic [PW-1:0]       prod_x, prod_y;
   logic [PAL_AW-1:0]   pal_addr;
   logic                pal_we;
   logic                oob;

   // Normalise the raster position before emitting
   always_comb begin
      col_over      = raster_col_ff >= geo.width;
      col_now       = col_over ? '0 : raster_col_ff;
      row_step      = col_over ? (raster_row_ff + CW'(1)) : raster_row_ff;
      row_now       = (row_step >= geo.height) ? '0 : row_step;
      col_inc       = col_now + CW'(1);
      row_inc       = row_now + CW'(1);
      raster_col_in = raster_col_ff;
      raster_row_in = raster_row_ff;
      if (in_valid && opcode == pus_pkg::OP_EMIT) begin
         if (col_inc >= geo.width) begin
            raster_col_in = '0;
            raster_row_in = (row_inc >= geo.height) ? '0 : row_inc;
         end else begin
            raster_col_in = col_inc;
            raster_row_in = row_now;
         end
      end
      s1_in.op       = opcode;
      s1_in.wi       = write_index;
      s1_in.color    = color_value;
      s1_in.pix      = pixel_value;
      s1_in.col      = col_now;
      s1_in.row      = row_now;
      s1_in.fend     = (col_now == geo.width - CW'(1)) && (row_now == geo.height - CW'(1));
      s1_in.in_image = 1'b0;
   end

   // Offset into the image and window test
   always_comb begin
      dx_full = $signed({2'b00, s1_ff.col}) - $signed({geo.off_x[OW-1], geo.off_x});
      dy_full = $signed({2'b00, s1_ff.row}) - $signed({geo.off_y[OW-1], geo.off_y});
      s2_in          = s1_ff;
      s2_in.in_image = !dx_full[OW] && (dx_full[OW-1:0] < {1'b0, geo.img_w}) &&
                       !dy_full[OW] && (dy_full[OW-1:0] < {1'b0, geo.img_h});
   end

   // Source coordinate through the scale reciprocal
   assign prod_x = PW'(dx_ff) * PW'(geo.recip);
   assign prod_y = PW'(dy_ff) * PW'(geo.recip);

   // Source address: linear index of a write or of the covered pixel
   always_comb begin
      if (s3_ff.op == pus_pkg::OP_WRITE_PIXEL) begin
         src_addr_in = SRC_AW'(s3_ff.wi);
      end else begin
         src_addr_in = SRC_AW'(sy_ff) * SRC_AW'(SRC_WIDTH) + SRC_AW'(sx_ff);
      end
      src_we_in = s3_vld_ff && (s3_ff.op == pus_pkg::OP_WRITE_PIXEL) &&
                  ({16'b0, s3_ff.wi} < 32'(SRC_DEPTH));
   end

   // Palette address and range check of the stored index
   always_comb begin
      if (s5_ff.op == pus_pkg::OP_WRITE_PALETTE) begin
         pal_addr = PAL_AW'(s5_ff.wi);
      end else begin
         pal_addr = PAL_AW'(src_q_ff);
      end
      pal_we = s5_vld_ff && (s5_ff.op == pus_pkg::OP_WRITE_PALETTE) &&
               ({16'b0, s5_ff.wi} < 32'(PALETTE_DEPTH));
      oob    = {1'b0, src_q_ff} >= 9'(PALETTE_DEPTH);
   end

   // Stage valids and raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         raster_col_ff <= '0;
         raster_row_ff <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         s4_vld_ff     <= 1'b0;
         s5_vld_ff     <= 1'b0;
         s6_vld_ff     <= 1'b0;
      end else begin
         raster_col_ff <= raster_col_in;
         raster_row_ff <= raster_row_in;
         s1_vld_ff     <= in_valid;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         s4_vld_ff     <= s3_vld_ff;
         s5_vld_ff     <= s4_vld_ff;
         s6_vld_ff     <= s5_vld_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      dx_ff       <= dx_full[CW-1:0];
      dy_ff       <= dy_full[CW-1:0];
      s3_ff       <= s2_ff;
      sx_ff       <= prod_x[pus_pkg::RECIP_SHIFT +: XW];
      sy_ff       <= prod_y[pus_pkg::RECIP_SHIFT +: YW];
      s4_ff       <= s3_ff;
      src_addr_ff <= src_addr_in;
      src_we_ff   <= src_we_in;
      s5_ff       <= s4_ff;
      s6_ff       <= s5_ff;
      oob_ff      <= oob;
   end

   // Source frame: write a pixel or read the covered one
   always_ff @(posedge clock) begin
      if (src_we_ff) begin
         src_mem[src_addr_ff] <= s4_ff.pix;
      end
      src_q_ff <= src_mem[src_addr_ff];
   end

   // Palette: write an entry or look up the colour
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_addr] <= s5_ff.color;
      end
      pal_q_ff <= pal_mem[pal_addr];
   end

   // Hand finished pixels to the result queue
   assign push                = s6_vld_ff && (s6_ff.op == pus_pkg::OP_EMIT);
   assign push_data.color     = (s6_ff.in_image && !oob_ff) ? pal_q_ff : pus_pkg::BORDER_COLOR;
   assign push_data.x         = s6_ff.col;
   assign push_data.y         = s6_ff.row;
   assign push_data.frame_end = s6_ff.fend;

endmodule

// File: src/pus_fifo.sv
module pus_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pus_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             out_valid,
   output pus_pkg::rsp_type out_data
);

   localparam int AW = pus_pkg::FIFO_AW;
   localparam int CW = pus_pkg::FIFO_CW;

   pus_pkg::rsp_type slot_ff [pus_pkg::FIFO_DEPTH];

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_pop    = out_valid && pop;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + AW'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + AW'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/palette_integer_upscale_scanout.sv
// Channel  Dir  Handshake    Payload
// req_ch   in   valid/ready  opcode, write_index, color_value, pixel_value
// rsp_ch   out  valid/ready  out_color, out_x, out_y, frame_end
// csr_ch   in   valid/ready  index (0 screen_width, 1 screen_height), data
//
// One request a clock while req ready is high; an emit request gives its pixel through
// the six-stage pipeline, which covers the source frame and palette reads.
// After reset and after each register write the geometry unit grows the scale step by
// step, then computes its reciprocal, with req ready low.
// Results queue in a 16-entry buffer; req ready also drops while 16 pixels are owed.
// Reset is synchronous; stores are not cleared and hold garbage until written.
module palette_integer_upscale_scanout #(
   parameter int SRC_WIDTH     = 320,
   parameter int SRC_HEIGHT    = 200,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic          clock,
   input  logic          reset,
   pus_req_if.sink       req_ch,
   pus_rsp_if.source     rsp_ch,
   pus_csr_if.sink       csr_ch
);

   localparam int CW = pus_pkg::FIFO_CW;

   pus_pkg::geo_type geo;
   pus_pkg::rsp_type push_data;
   pus_pkg::rsp_type out_data;

   logic          push;
   logic          req_rdy;
   logic          req_xfer;
   logic          emit_xfer;
   logic          rsp_xfer;
   logic [CW-1:0] credit_ff, credit_in;

   // Accept while geometry is settled and queue space is reserved
   assign req_rdy   = !geo.busy && (credit_ff < CW'(pus_pkg::FIFO_DEPTH));
   assign req_xfer  = req_ch.valid && req_rdy;
   assign emit_xfer = req_xfer && (req_ch.opcode == pus_pkg::OP_EMIT);
   assign rsp_xfer  = rsp_ch.valid && rsp_ch.ready;

   assign req_ch.ready = req_rdy;
   assign csr_ch.ready = 1'b1;

   // Count pixels owed: in flight plus queued
   always_comb begin
      credit_in = credit_ff;
      if (emit_xfer && !rsp_xfer) begin
         credit_in = credit_ff + CW'(1);
      end else if (rsp_xfer && !emit_xfer) begin
         credit_in = credit_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   pus_geom #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .geo       (geo)
   );

   pus_pipe #(
      .SRC_WIDTH     (SRC_WIDTH),
      .SRC_HEIGHT    (SRC_HEIGHT),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_xfer),
      .opcode      (req_ch.opcode),
      .write_index (req_ch.write_index),
      .color_value (req_ch.color_value),
      .pixel_value (req_ch.pixel_value),
      .geo         (geo),
      .push        (push),
      .push_data   (push_data)
   );

   pus_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_data  (out_data)
   );

   assign rsp_ch.out_color = out_data.color;
   assign rsp_ch.out_x     = out_data.x;
   assign rsp_ch.out_y     = out_data.y;
   assign rsp_ch.frame_end = out_data.frame_end;

endmodule

// File: test/tb_palette_integer_upscale_scanout.sv
module tb_palette_integer_upscale_scanout;

   localparam int SRC_W          = 320;
   localparam int SRC_H          = 200;
   localparam int PAL_DEPTH      = 256;
   localparam int SRC_PIXELS     = SRC_W * SRC_H;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT    = 3000;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 12;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] write_index;
      logic [31:0] color_value;
      logic [7:0]  pixel_value;
   } scan_req_type;

   // Which side carries the heavier share of idle cycles
   typedef enum int {
      GAPS_RX_HEAVY,
      GAPS_TX_HEAVY,
      GAPS_NONE
   } gap_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pus_req_if req_ch ();
   pus_rsp_if rsp_ch ();
   pus_csr_if csr_ch ();

   palette_integer_upscale_scanout dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Requests waiting to be offered, and pixels owed by the block
   scan_req_type     pending_reqs[$];
   pus_pkg::rsp_type expected_pixels[$];
   int               reqs_owed = 0;

   // Shadow of the block's stores, geometry and raster position
   logic [31:0] palette_shadow [PAL_DEPTH];
   logic [7:0]  frame_shadow [SRC_PIXELS];
   bit          frame_loaded [SRC_PIXELS];
   int          scr_w = int'(pus_pkg::WIDTH_RESET);
   int          scr_h = int'(pus_pkg::HEIGHT_RESET);
   int          scan_col = 0;
   int          scan_row = 0;
   // Raster position as seen while building the stimulus
   int          plan_col = 0;
   int          plan_row = 0;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_arm = 1'b0;
   bit          hold_fired = 1'b0;
   int          hold_left = 0;
   int          idle_cycles = 0;
   int          mismatches = 0;

   always #5 clock = ~clock;

   function automatic int eff_dim(input int d);
      return (d == 0) ? 1 : d;
   endfunction

   // Source pixel behind a screen position; zero when it lies on the border
   function automatic bit source_under(input int col, row, w, h, output int addr);
      int s, ox, oy;
      s = (w / SRC_W < h / SRC_H) ? w / SRC_W : h / SRC_H;
      if (s < 1) s = 1;
      ox = (w - SRC_W * s) / 2;
      oy = (h - SRC_H * s) / 2;
      addr = 0;
      if (col < ox || col >= ox + SRC_W * s || row < oy || row >= oy + SRC_H * s)
         return 1'b0;
      addr = ((row - oy) / s) * SRC_W + (col - ox) / s;
      return 1'b1;
   endfunction

   // Pull the position back inside the frame after a size change
   function automatic void wrap_position(inout int col, inout int row, input int w, h);
      if (col >= w) begin
         col = 0;
         row++;
      end
      if (row >= h) row = 0;
   endfunction

   function automatic void advance_position(inout int col, inout int row, input int w, h);
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
   endfunction

   // Apply one accepted request to the shadow state; emits owe one pixel
   function automatic void predict_scanout(input scan_req_type r);
      int               w, h, addr;
      pus_pkg::rsp_type px;
      w = eff_dim(scr_w);
      h = eff_dim(scr_h);
      case (r.opcode)
         pus_pkg::OP_WRITE_PALETTE: begin
            if (r.write_index < PAL_DEPTH)
               palette_shadow[r.write_index[7:0]] = r.color_value;
         end
         pus_pkg::OP_WRITE_PIXEL: begin
            if (r.write_index < SRC_PIXELS) frame_shadow[r.write_index] = r.pixel_value;
         end
         pus_pkg::OP_EMIT: begin
            wrap_position(scan_col, scan_row, w, h);
            px.x         = pus_pkg::COORD_W'(scan_col);
            px.y         = pus_pkg::COORD_W'(scan_row);
            px.frame_end = (scan_col == w - 1) && (scan_row == h - 1);
            if (source_under(scan_col, scan_row, w, h, addr))
               px.color = palette_shadow[frame_shadow[16'(addr)]];
            else
               px.color = pus_pkg::BORDER_COLOR;
            expected_pixels.push_back(px);
            advance_position(scan_col, scan_row, w, h);
         end
         default: ;
      endcase
   endfunction

   function automatic void push_request(input scan_req_type r);
      pending_reqs.push_back(r);
      reqs_owed++;
   endfunction

   function automatic void queue_palette(input logic [15:0] idx, input logic [31:0] color);
      push_request('{pus_pkg::OP_WRITE_PALETTE, idx, color, 8'($urandom)});
   endfunction

   function automatic void queue_pixel(input logic [15:0] idx, input logic [7:0] value);
      if (idx < SRC_PIXELS) frame_loaded[idx] = 1'b1;
      push_request('{pus_pkg::OP_WRITE_PIXEL, idx, 32'($urandom), value});
   endfunction

   // Queue one emit, first writing the source pixel it will read if still unwritten
   function automatic void queue_emit();
      int w, h, addr;
      w = eff_dim(scr_w);
      h = eff_dim(scr_h);
      wrap_position(plan_col, plan_row, w, h);
      if (source_under(plan_col, plan_row, w, h, addr) && !frame_loaded[16'(addr)])
         queue_pixel(16'(addr), 8'($urandom));
      push_request('{pus_pkg::OP_EMIT, 16'($urandom), 32'($urandom), 8'($urandom)});
      advance_position(plan_col, plan_row, w, h);
   endfunction

   function automatic void set_idling(input gap_mode_type mode);
      case (mode)
         GAPS_RX_HEAVY: begin
            send_idle_pct = 37;
            recv_idle_pct = 49;
         end
         GAPS_TX_HEAVY: begin
            send_idle_pct = 49;
            recv_idle_pct = 37;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Hold until every request is taken and every pixel returned, then let the pipe settle
   task automatic wait_drained();
      while (reqs_owed != 0 || expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_screen_reg(input logic [pus_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= pus_pkg::COORD_W'(value);
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == pus_pkg::CSR_SCREEN_WIDTH) scr_w = value;
      else scr_h = value;
   endtask

   // Set the screen size, then stream emits with stray writes mixed in
   task automatic run_phase(input int w, h, emits, input gap_mode_type mode,
                            input bit rx_hold);
      int pick;
      write_screen_reg(pus_pkg::CSR_SCREEN_WIDTH, w);
      write_screen_reg(pus_pkg::CSR_SCREEN_HEIGHT, h);
      set_idling(mode);
      repeat (emits) begin
         if ($urandom_range(99) < 15) begin
            pick = $urandom_range(99);
            if (pick < 55)
               queue_palette(16'($urandom_range(PAL_DEPTH - 1)), $urandom);
            else if (pick < 65)
               queue_palette(16'($urandom_range(16'hFFFF, PAL_DEPTH)), $urandom);
            else if (pick < 85)
               queue_pixel(16'($urandom_range(SRC_PIXELS - 1)), 8'($urandom));
            else if (pick < 93)
               queue_pixel(16'($urandom_range(16'hFFFF, SRC_PIXELS)), 8'($urandom));
            else
               push_request('{OP_UNUSED, 16'($urandom), 32'($urandom), 8'($urandom)});
         end
         queue_emit();
      end
      if (rx_hold) hold_arm = 1'b1;
      wait_drained();
   endtask

   // Request driver: predict on each transfer, then offer the next request or idle
   always @(posedge clock) begin
      scan_req_type next_req;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_scanout('{req_ch.opcode, req_ch.write_index, req_ch.color_value,
                              req_ch.pixel_value});
            reqs_owed--;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.opcode      <= next_req.opcode;
               req_ch.write_index <= next_req.write_index;
               req_ch.color_value <= next_req.color_value;
               req_ch.pixel_value <= next_req.pixel_value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the block fills and back-pressures
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_fired <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_fired) begin
         hold_left  <= RX_HOLD_CYCLES;
         hold_fired <= 1'b1;
      end
   end

   // Pixel monitor: compare each transfer with the oldest owed pixel
   always @(posedge clock) begin
      pus_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel at (%0d,%0d) with none owed", rsp_ch.out_x, rsp_ch.out_y);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("out_color", want.color, rsp_ch.out_color);
               check_field("out_x", 32'(want.x), 32'(rsp_ch.out_x));
               check_field("out_y", 32'(want.y), 32'(rsp_ch.out_y));
               check_field("frame_end", 32'(want.frame_end), 32'(rsp_ch.frame_end));
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run when no channel has moved a transfer for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.opcode      = pus_pkg::OP_EMIT;
      req_ch.write_index = '0;
      req_ch.color_value = '0;
      req_ch.pixel_value = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = pus_pkg::CSR_SCREEN_WIDTH;
      csr_ch.data        = '0;
      set_idling(GAPS_RX_HEAVY);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Field extremes, out-of-range writes that must be dropped, the unused opcode,
      // and border pixels at the reset screen size
      queue_palette(16'd0, 32'h0000_0000);
      queue_palette(16'(PAL_DEPTH - 1), 32'hFFFF_FFFF);
      queue_palette(16'(PAL_DEPTH), 32'($urandom));
      queue_palette(16'hFFFF, 32'($urandom));
      queue_pixel(16'd0, 8'h00);
      queue_pixel(16'(SRC_PIXELS - 1), 8'hFF);
      queue_pixel(16'(SRC_PIXELS), 8'($urandom));
      queue_pixel(16'hFFFF, 8'hFF);
      push_request('{OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF});
      repeat (8) queue_emit();
      wait_drained();

      // Fill the whole palette so every source index resolves to a written colour
      for (int i = 0; i < PAL_DEPTH; i++) queue_palette(16'(i), $urandom);
      wait_drained();

      // Zero size, entered mid-row from the reset size: every pixel ends a frame
      run_phase(0, 0, 10, GAPS_RX_HEAVY, 1'b0);
      run_phase(4095, 4095, 20, GAPS_RX_HEAVY, 1'b0);
      // Largest scale, image from the top left corner
      run_phase(3840, 2400, 200, GAPS_TX_HEAVY, 1'b0);
      // Scale two with a narrow border, crossing a row end
      run_phase(645, 401, 450, GAPS_TX_HEAVY, 1'b0);
      run_phase(320, 200, 40, GAPS_TX_HEAVY, 1'b0);
      // Screen smaller than the source: cropped, short frames, receiver held off
      run_phase(16, 8, 150, GAPS_NONE, 1'b1);
      repeat (4) run_phase($urandom_range(40), $urandom_range(20), 20, GAPS_NONE, 1'b0);
      run_phase($urandom_range(4095), $urandom_range(4095), 30, GAPS_NONE, 1'b0);

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
src/pus_pkg.sv
src/pus_if.sv
src/pus_geom.sv
src/pus_pipe.sv
src/pus_fifo.sv
src/palette_integer_upscale_scanout.sv
test/tb_palette_integer_upscale_scanout.sv
